[src/biaxc_pkg.sv]
// Shared types and constants for the block image assembler with XOR checks.
// Holds the parse phase and controller state encodings and the command and
// status structs. No dependencies.
`timescale 1ns / 1ps
package biaxc_pkg;

  localparam int IMAGE_DEPTH_DEF = 65536;
  localparam int STAGE_DEPTH_DEF = 4096;
  localparam int BYTE_W          = 8;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_BLKHDR  = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_FLAGLEN = 6'b001000,
    PH_FLAGOFF = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_RUN    = 6'b000010,
    ST_COPY   = 6'b000100,
    ST_RDLO   = 6'b001000,
    ST_RDHI   = 6'b010000,
    ST_RESULT = 6'b100000
  } ctl_state_e;

  typedef struct packed {
    logic take;
    logic clr;
    logic copy_rd;
    logic rd_lo;
    logic rd_hi;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic copy_req;
    logic read_req;
    logic copy_last;
    logic clr_last;
  } dp_status_t;

endpackage

[src/block_image_assembler_xor_check.sv]
// Top level of the block image assembler with XOR-checked blocks.
// Depends on biaxc_pkg, biaxc_ctrl and biaxc_dp (which holds two biaxc_ram).
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-----------------------------------
//   input   | in        | in_valid_i / in_ready_o  | file_byte_i
//   output  | out       | out_valid_o / out_ready_i| first_flag_byte_o, second_flag_byte_o,
//           |           |                          | last_word_o
//
// File bytes are taken while the controller runs. A byte that ends a block
// whose fold matches its checksum starts a copy of min(length, STAGE_DEPTH)
// staged bytes, one per cycle, through the single read port of the staging
// memory. A byte that completes a flag offset is followed by two reads through
// the image memory's single read port, then a load of the result register.
// After reset the image memory is cleared, one byte per cycle, over all
// IMAGE_DEPTH addresses; no item is accepted during that pass.
// A result waits in its own register, so parsing goes on while it is stalled;
// only the next flag result waits for that register to empty.
`timescale 1ns / 1ps
module block_image_assembler_xor_check #(
  parameter int IMAGE_DEPTH = biaxc_pkg::IMAGE_DEPTH_DEF,
  parameter int STAGE_DEPTH = biaxc_pkg::STAGE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] file_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] first_flag_byte_o,
  output logic [7:0] second_flag_byte_o,
  output logic       last_word_o
);

  biaxc_pkg::ctl_cmd_t   cmd;
  biaxc_pkg::dp_status_t status;

  // The controller decides per cycle what the datapath does.
  biaxc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath parses fields, folds checksums and owns both memories.
  biaxc_dp #(
    .IMAGE_DEPTH(IMAGE_DEPTH),
    .STAGE_DEPTH(STAGE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .file_byte_i       (file_byte_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .first_flag_byte_o (first_flag_byte_o),
    .second_flag_byte_o(second_flag_byte_o),
    .last_word_o       (last_word_o)
  );

  // No item is taken while the image memory is being cleared.
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !in_ready_o)
    else $error("item accepted during clearing pass");

  // A completed flag offset stalls the input until its result is loaded.
  a_read_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && status.read_req) |=> !in_ready_o)
    else $error("input not stalled for flag read");

  // A new result never overwrites one that has not been taken.
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // A block copy never runs alongside byte intake.
  a_copy_excludes_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.copy_rd |-> !in_ready_o)
    else $error("input taken during block copy");

endmodule

[src/biaxc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module biaxc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/biaxc_ctrl.sv]
// Controller state machine: sequences the clearing pass, byte intake, block
// copies, flag reads and the result register. Depends on biaxc_pkg.
`timescale 1ns / 1ps
module biaxc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  biaxc_pkg::dp_status_t status_i,
  output biaxc_pkg::ctl_cmd_t   cmd_o
);

  biaxc_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      biaxc_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = biaxc_pkg::ST_RUN;
      end
      biaxc_pkg::ST_RUN: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.copy_req) state_d = biaxc_pkg::ST_COPY;
        if (in_valid_i && status_i.read_req) state_d = biaxc_pkg::ST_RDLO;
      end
      biaxc_pkg::ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (status_i.copy_last) state_d = biaxc_pkg::ST_RUN;
      end
      biaxc_pkg::ST_RDLO: begin
        cmd_o.rd_lo = 1'b1;
        state_d = biaxc_pkg::ST_RDHI;
      end
      biaxc_pkg::ST_RDHI: begin
        cmd_o.rd_hi = 1'b1;
        state_d = biaxc_pkg::ST_RESULT;
      end
      biaxc_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = biaxc_pkg::ST_RUN;
        end
      end
      default: state_d = biaxc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= biaxc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/biaxc_dp.sv]
// Datapath: field parsing registers, XOR fold, staging and image memories,
// copy and flag read address logic, and the result register.
// Depends on biaxc_pkg and biaxc_ram.
`timescale 1ns / 1ps
module biaxc_dp #(
  parameter int IMAGE_DEPTH = biaxc_pkg::IMAGE_DEPTH_DEF,
  parameter int STAGE_DEPTH = biaxc_pkg::STAGE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            file_byte_i,
  input  biaxc_pkg::ctl_cmd_t   cmd_i,
  output biaxc_pkg::dp_status_t status_o,
  output logic [7:0]            first_flag_byte_o,
  output logic [7:0]            second_flag_byte_o,
  output logic                  last_word_o
);

  localparam int IAW = $clog2(IMAGE_DEPTH);
  localparam int SAW = $clog2(STAGE_DEPTH);

  biaxc_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] image_size_q, image_size_d;
  logic [15:0] blocks_left_q, blocks_left_d;
  logic [31:0] offset_q, offset_d;
  logic [15:0] checksum_q, checksum_d;
  logic [15:0] length_q, length_d;
  logic [15:0] pidx_q, pidx_d;
  logic [15:0] xor_q, xor_d;
  logic [15:0] flags_left_q, flags_left_d;
  logic [31:0] flag_acc_q, flag_acc_d;
  logic [31:0] rd_addr_q, rd_addr_d;
  logic        rd_last_q, rd_last_d;
  logic        copy_req, read_req;

  logic [SAW-1:0] copy_k_q;
  logic [SAW:0]   copy_lim_q;
  logic           wr_pend_q;
  logic [IAW-1:0] wr_addr_q;
  logic [IAW-1:0] clr_cnt_q;
  logic           rd_inr_q;
  logic [7:0]     lo_q;
  logic [7:0]     first_q, second_q;
  logic           last_q;

  logic [7:0]  b;
  logic [15:0] fold_next, fold_final;
  logic [15:0] pidx_inc, new_len, flags_dec;
  logic        blocks_zero;

  logic           stage_we;
  logic [7:0]     stage_rdata;
  logic           img_we, img_re;
  logic [IAW-1:0] img_waddr, img_raddr;
  logic [7:0]     img_wdata, img_rdata;
  logic [32:0]    copy_a, rd_a;
  logic           copy_inr, rd_inr;

  assign b = file_byte_i & biaxc_pkg::BYTE_MASK;

  // XOR fold over big-endian 16-bit units; an odd final byte folds as itself.
  always_comb begin
    pidx_inc    = pidx_q + 16'd1;
    fold_next   = pidx_q[0] ? (xor_q ^ {8'd0, b}) : (xor_q ^ {b, 8'd0});
    fold_final  = length_q[0] ? (xor_q ^ {8'd0, b}) : fold_next;
    new_len     = {length_q[7:0], b};
    flags_dec   = flags_left_q - 16'd1;
    blocks_zero = (blocks_left_q == 16'd0);
  end

  always_comb begin
    phase_d       = phase_q;
    fbc_d         = fbc_q;
    image_size_d  = image_size_q;
    blocks_left_d = blocks_left_q;
    offset_d      = offset_q;
    checksum_d    = checksum_q;
    length_d      = length_q;
    pidx_d        = pidx_q;
    xor_d         = xor_q;
    flags_left_d  = flags_left_q;
    flag_acc_d    = flag_acc_q;
    rd_addr_d     = rd_addr_q;
    rd_last_d     = rd_last_q;
    copy_req      = 1'b0;
    read_req      = 1'b0;
    case (phase_q)
      biaxc_pkg::PH_HEADER: begin
        if (fbc_q >= 4'd8 && fbc_q < 4'd12) image_size_d = {image_size_q[23:0], b};
        else if (fbc_q == 4'd12 || fbc_q == 4'd13) blocks_left_d = {blocks_left_q[7:0], b};
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd15) begin
          fbc_d = 4'd0;
          if (blocks_zero) phase_d = biaxc_pkg::PH_FLAGLEN;
          else begin
            blocks_left_d = blocks_left_q - 16'd1;
            phase_d = biaxc_pkg::PH_BLKHDR;
          end
        end
      end
      biaxc_pkg::PH_BLKHDR: begin
        if (fbc_q < 4'd4) offset_d = {offset_q[23:0], b};
        else if (fbc_q < 4'd6) checksum_d = {checksum_q[7:0], b};
        else length_d = new_len;
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd7) begin
          pidx_d = 16'd0;
          xor_d  = 16'd0;
          fbc_d  = 4'd0;
          if (new_len != 16'd0) phase_d = biaxc_pkg::PH_PAYLOAD;
          else if (blocks_zero) phase_d = biaxc_pkg::PH_FLAGLEN;
          else blocks_left_d = blocks_left_q - 16'd1;
        end
      end
      biaxc_pkg::PH_PAYLOAD: begin
        xor_d  = fold_next;
        pidx_d = pidx_inc;
        if (pidx_inc == length_q) begin
          xor_d    = fold_final;
          copy_req = (fold_final == checksum_q);
          fbc_d    = 4'd0;
          if (blocks_zero) phase_d = biaxc_pkg::PH_FLAGLEN;
          else begin
            blocks_left_d = blocks_left_q - 16'd1;
            phase_d = biaxc_pkg::PH_BLKHDR;
          end
        end
      end
      biaxc_pkg::PH_FLAGLEN: begin
        flags_left_d = {flags_left_q[7:0], b};
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd1) begin
          fbc_d      = 4'd0;
          flag_acc_d = 32'd0;
          phase_d = ({flags_left_q[7:0], b} == 16'd0) ? biaxc_pkg::PH_DONE
                                                      : biaxc_pkg::PH_FLAGOFF;
        end
      end
      biaxc_pkg::PH_FLAGOFF: begin
        flag_acc_d = {flag_acc_q[23:0], b};
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd3) begin
          fbc_d        = 4'd0;
          flag_acc_d   = 32'd0;
          flags_left_d = flags_dec;
          rd_addr_d    = {flag_acc_q[23:0], b};
          rd_last_d    = (flags_dec == 16'd0);
          read_req     = 1'b1;
          if (flags_dec == 16'd0) phase_d = biaxc_pkg::PH_DONE;
        end
      end
      biaxc_pkg::PH_DONE: begin
        phase_d = biaxc_pkg::PH_DONE;
      end
      default: phase_d = biaxc_pkg::PH_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= biaxc_pkg::PH_HEADER;
      fbc_q         <= '0;
      image_size_q  <= '0;
      blocks_left_q <= '0;
      offset_q      <= '0;
      checksum_q    <= '0;
      length_q      <= '0;
      pidx_q        <= '0;
      xor_q         <= '0;
      flags_left_q  <= '0;
      flag_acc_q    <= '0;
    end else if (cmd_i.take) begin
      phase_q       <= phase_d;
      fbc_q         <= fbc_d;
      image_size_q  <= image_size_d;
      blocks_left_q <= blocks_left_d;
      offset_q      <= offset_d;
      checksum_q    <= checksum_d;
      length_q      <= length_d;
      pidx_q        <= pidx_d;
      xor_q         <= xor_d;
      flags_left_q  <= flags_left_d;
      flag_acc_q    <= flag_acc_d;
    end
  end

  // Copy address and range check for the staged byte at copy_k_q, and the flag read address and its range check.
  assign copy_a   = {1'b0, offset_q} + 33'(copy_k_q);
  assign copy_inr = (copy_a < {1'b0, image_size_q}) && (copy_a < 33'(IMAGE_DEPTH));
  assign rd_a     = cmd_i.rd_lo ? {1'b0, rd_addr_q} : ({1'b0, rd_addr_q} + 33'd1);
  assign rd_inr   = (rd_a < {1'b0, image_size_q}) && (rd_a < 33'(IMAGE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_k_q   <= '0;
      copy_lim_q <= '0;
      wr_pend_q  <= 1'b0;
      clr_cnt_q  <= '0;
      rd_last_q  <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.copy_rd && copy_inr;
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + IAW'(1);
      if (cmd_i.take && copy_req) begin
        copy_k_q   <= '0;
        copy_lim_q <= (17'(length_q) < 17'(STAGE_DEPTH)) ? (SAW+1)'(length_q)
                                                       : (SAW+1)'(STAGE_DEPTH);
      end else if (cmd_i.copy_rd) begin
        copy_k_q <= copy_k_q + SAW'(1);
      end
      if (cmd_i.take) rd_last_q <= rd_last_d;
      if (cmd_i.load_out) last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rd_addr_q <= rd_addr_d;
    if (cmd_i.copy_rd) wr_addr_q <= copy_a[IAW-1:0];
    if (cmd_i.rd_lo || cmd_i.rd_hi) rd_inr_q <= rd_inr;
    if (cmd_i.rd_hi) lo_q <= rd_inr_q ? img_rdata : 8'd0;
    if (cmd_i.load_out) begin
      first_q  <= lo_q;
      second_q <= rd_inr_q ? img_rdata : 8'd0;
    end
  end

  assign stage_we = cmd_i.take && (phase_q == biaxc_pkg::PH_PAYLOAD)
                    && (17'(pidx_q) < 17'(STAGE_DEPTH));

  biaxc_ram #(
    .WIDTH(biaxc_pkg::BYTE_W),
    .DEPTH(STAGE_DEPTH)
  ) u_stage_ram (
    .clk_i  (clk_i),
    .we_i   (stage_we),
    .waddr_i(pidx_q[SAW-1:0]),
    .wdata_i(b),
    .re_i   (cmd_i.copy_rd),
    .raddr_i(copy_k_q),
    .rdata_o(stage_rdata)
  );

  assign img_we    = cmd_i.clr || wr_pend_q;
  assign img_waddr = cmd_i.clr ? clr_cnt_q : wr_addr_q;
  assign img_wdata = cmd_i.clr ? 8'd0 : stage_rdata;
  assign img_re    = cmd_i.rd_lo || cmd_i.rd_hi;
  assign img_raddr = rd_a[IAW-1:0];

  biaxc_ram #(
    .WIDTH(biaxc_pkg::BYTE_W),
    .DEPTH(IMAGE_DEPTH)
  ) u_image_ram (
    .clk_i  (clk_i),
    .we_i   (img_we),
    .waddr_i(img_waddr),
    .wdata_i(img_wdata),
    .re_i   (img_re),
    .raddr_i(img_raddr),
    .rdata_o(img_rdata)
  );

  assign status_o.copy_req  = copy_req;
  assign status_o.read_req  = read_req;
  assign status_o.copy_last = ((SAW+1)'(copy_k_q) + (SAW+1)'(1)) == copy_lim_q;
  assign status_o.clr_last  = (clr_cnt_q == IAW'(IMAGE_DEPTH - 1));

  assign first_flag_byte_o  = first_q;
  assign second_flag_byte_o = second_q;
  assign last_word_o        = last_q;

endmodule
